FILE: src/ncc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared constants and codes for the nearest-centroid classifier.
// ----------------------------------------------------------------------------
package ncc_pkg;

   // default table sizes
   localparam int DEF_MAX_FEATURES  = 16;
   localparam int DEF_MAX_CENTROIDS = 16;

   // field widths
   localparam int OP_W     = 2;
   localparam int INDEX_W  = 4;
   localparam int VALUE_W  = 32;
   localparam int LABEL_W  = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   // divider length: quotient bits
   localparam int DIV_STEPS = 32;

   // input operation codes
   localparam logic [OP_W-1:0] OP_LIMIT_LO = 2'd0;
   localparam logic [OP_W-1:0] OP_LIMIT_HI = 2'd1;
   localparam logic [OP_W-1:0] OP_CENTROID = 2'd2;
   localparam logic [OP_W-1:0] OP_POINT    = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_MODEL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DIM       = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FEATURE_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTROID_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODEL_VALID    = 2'd2;

endpackage

FILE: src/nearest_centroid_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_classifier
// Assigns a streamed point to its nearest centroid using one shared divider
// and one shared multiply-accumulate path under a small sequencer.
// ----------------------------------------------------------------------------
// load transactions never make the block busy; a point coordinate that is accumulated
// runs a 32-step restoring divider, then a read/square/add pass per centroid;
// other coordinates leave the block idle
// the last coordinate adds a status check, then a minimum search when there is more
// than one centroid and an ok status, plus any wait while a stalled result holds
// synchronous active-high reset resets control state and marks the sums empty, not the tables
module nearest_centroid_classifier #(
   parameter int MAX_FEATURES  = ncc_pkg::DEF_MAX_FEATURES,
   parameter int MAX_CENTROIDS = ncc_pkg::DEF_MAX_CENTROIDS
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ncc_pkg::OP_W-1:0]          req_op,
   input  logic [ncc_pkg::INDEX_W-1:0]       req_feature_index,
   input  logic [ncc_pkg::INDEX_W-1:0]       req_centroid_index,
   input  logic signed [ncc_pkg::VALUE_W-1:0] req_value,
   input  logic                              req_element_null,
   input  logic                              req_last,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ncc_pkg::LABEL_W-1:0]       rsp_label,
   output logic [ncc_pkg::STATUS_W-1:0]      rsp_status,
   // register port
   input  logic                              csr_wr_en,
   input  logic [ncc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ncc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int FW     = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int CW     = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
   localparam int CDEPTH = MAX_CENTROIDS * MAX_FEATURES;
   localparam int AW     = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
   localparam int VW     = ncc_pkg::VALUE_W;
   localparam int CNTW   = ncc_pkg::COUNT_W;
   localparam int BCW    = $clog2(ncc_pkg::DIV_STEPS);

   typedef enum logic [3:0] {
      S_IDLE, S_NORM, S_DIV, S_FIX, S_CRD, S_CSQ, S_CMUL, S_CACC,
      S_FIN, S_MRD, S_MCMP, S_EMIT
   } state_type;

   // registers
   state_type                 state_ff, state_in;
   logic [CNTW-1:0]           fc_ff, fc_in, cc_ff, cc_in;
   logic                      mv_ff, mv_in;
   logic [CNTW-1:0]           count_ff, count_in;
   logic                      saw_null_ff, saw_null_in;
   logic [MAX_CENTROIDS-1:0]  live_ff, live_in;
   logic [FW-1:0]             f_ff, f_in;
   logic signed [VW-1:0]      x_ff, x_in;
   logic                      last_ff, last_in;
   logic [33:0]               rem_ff, rem_in;
   logic [31:0]               dvd_ff, dvd_in;
   logic [32:0]               dvs_ff, dvs_in;
   logic [31:0]               quo_ff, quo_in;
   logic                      neg_ff, neg_in, sat_ff, sat_in, zero_ff, zero_in;
   logic [BCW-1:0]            bitc_ff, bitc_in;
   logic signed [VW-1:0]      norm_ff, norm_in;
   logic [CW-1:0]             c_ff, c_in;
   logic [31:0]               m_ff, m_in;
   logic [63:0]               sq_ff, sq_in;
   logic [63:0]               best_ff, best_in;
   logic [ncc_pkg::LABEL_W-1:0]  lbl_ff, lbl_in;
   logic [ncc_pkg::STATUS_W-1:0] st_ff, st_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ncc_pkg::LABEL_W-1:0]  rsp_label_ff, rsp_label_in;
   logic [ncc_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // memories and their registered read data
   logic signed [VW-1:0] lo_mem   [MAX_FEATURES];
   logic signed [VW-1:0] hi_mem   [MAX_FEATURES];
   logic signed [VW-1:0] cent_mem [CDEPTH];
   logic [63:0]          sum_mem  [MAX_CENTROIDS];
   logic signed [VW-1:0] lo_rd_ff, hi_rd_ff, cent_rd_ff;
   logic [63:0]          sum_rd_ff;

   // combinational helpers
   logic                 req_acc;
   logic                 counts_ok;
   logic                 lim_wr_ok, cent_wr_ok;
   logic [FW-1:0]        fi_addr;
   logic [AW-1:0]        cent_waddr, cent_raddr;
   logic                 sum_we;
   logic [63:0]          sum_wdata;
   logic signed [32:0]   range_w, num_w;
   logic [32:0]          mag_w;
   logic [33:0]          trial_w;
   logic signed [32:0]   diff_w;
   logic [32:0]          dmag_w;
   logic [64:0]          acc_w;
   logic [63:0]          sum_cur_w;
   logic                 c_last_w;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_label  = rsp_label_ff;
   assign rsp_status = rsp_status_ff;

   assign counts_ok = (fc_ff != '0) && (32'(fc_ff) <= MAX_FEATURES) &&
                      (cc_ff != '0) && (32'(cc_ff) <= MAX_CENTROIDS);

   // load write decode
   assign lim_wr_ok  = (32'(req_feature_index) < MAX_FEATURES);
   assign cent_wr_ok = lim_wr_ok && (32'(req_centroid_index) < MAX_CENTROIDS);
   assign fi_addr    = FW'(req_feature_index);
   assign cent_waddr = AW'(32'(req_centroid_index) * MAX_FEATURES +
                           32'(req_feature_index));
   assign cent_raddr = AW'(32'(c_ff) * MAX_FEATURES + 32'(f_ff));

   // normalisation operands
   assign range_w = 33'(hi_rd_ff) - 33'(lo_rd_ff);
   assign num_w   = 33'(x_ff) - 33'(lo_rd_ff);
   assign mag_w   = num_w[32] ? 33'(-num_w) : 33'(num_w);
   assign trial_w = {rem_ff[32:0], dvd_ff[31]};

   // distance step
   assign diff_w    = 33'(norm_ff) - 33'(cent_rd_ff);
   assign dmag_w    = diff_w[32] ? 33'(-diff_w) : 33'(diff_w);
   assign sum_cur_w = live_ff[c_ff] ? sum_rd_ff : 64'd0;
   assign acc_w     = {1'b0, sum_cur_w} + {1'b0, sq_ff};
   assign sum_we    = (state_ff == S_CACC);
   assign sum_wdata = acc_w[64] ? {64{1'b1}} : acc_w[63:0];
   assign c_last_w  = ((32'(c_ff) + 1) == 32'(cc_ff));

   // limit tables
   always_ff @(posedge clock) begin
      if (req_acc && lim_wr_ok && req_op == ncc_pkg::OP_LIMIT_LO) begin
         lo_mem[fi_addr] <= req_value;
      end
      if (req_acc && lim_wr_ok && req_op == ncc_pkg::OP_LIMIT_HI) begin
         hi_mem[fi_addr] <= req_value;
      end
      lo_rd_ff <= lo_mem[FW'(count_ff)];
      hi_rd_ff <= hi_mem[FW'(count_ff)];
   end

   // centroid table
   always_ff @(posedge clock) begin
      if (req_acc && cent_wr_ok && req_op == ncc_pkg::OP_CENTROID) begin
         cent_mem[cent_waddr] <= req_value;
      end
      cent_rd_ff <= cent_mem[cent_raddr];
   end

   // distance sums
   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[c_ff] <= sum_wdata;
      end
      sum_rd_ff <= sum_mem[c_ff];
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      fc_in         = fc_ff;
      cc_in         = cc_ff;
      mv_in         = mv_ff;
      count_in      = count_ff;
      saw_null_in   = saw_null_ff;
      live_in       = live_ff;
      f_in          = f_ff;
      x_in          = x_ff;
      last_in       = last_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      dvs_in        = dvs_ff;
      quo_in        = quo_ff;
      neg_in        = neg_ff;
      sat_in        = sat_ff;
      zero_in       = zero_ff;
      bitc_in       = bitc_ff;
      norm_in       = norm_ff;
      c_in          = c_ff;
      m_in          = m_ff;
      sq_in         = sq_ff;
      best_in       = best_ff;
      lbl_in        = lbl_ff;
      st_in         = st_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_label_in  = rsp_label_ff;
      rsp_status_in = rsp_status_ff;

      // register writes
      if (csr_wr_en) begin
         case (csr_index)
            ncc_pkg::CSR_FEATURE_COUNT:  fc_in = csr_wdata;
            ncc_pkg::CSR_CENTROID_COUNT: cc_in = csr_wdata;
            ncc_pkg::CSR_MODEL_VALID:    mv_in = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc && req_op == ncc_pkg::OP_POINT) begin
               f_in    = FW'(count_ff);
               x_in    = req_value;
               last_in = req_last;
               if (count_ff != {CNTW{1'b1}}) begin
                  count_in = count_ff + 1'b1;
               end
               if (req_element_null) begin
                  saw_null_in = 1'b1;
               end
               if (!req_element_null && counts_ok && count_ff < fc_ff) begin
                  state_in = S_NORM;
               end else if (req_last) begin
                  state_in = S_FIN;
               end
            end
         end
         // range check and divider set-up
         S_NORM: begin
            zero_in = (range_w <= 0);
            neg_in  = num_w[32];
            sat_in  = ({8'd0, mag_w} >= {range_w, 8'd0});
            dvs_in  = range_w;
            rem_in  = 34'(mag_w[32:8]);
            dvd_in  = {mag_w[7:0], 24'd0};
            quo_in  = '0;
            bitc_in = '0;
            state_in = S_DIV;
         end
         // one restoring step per cycle
         S_DIV: begin
            if (trial_w >= {1'b0, dvs_ff}) begin
               rem_in = trial_w - {1'b0, dvs_ff};
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = trial_w;
               quo_in = {quo_ff[30:0], 1'b0};
            end
            dvd_in  = {dvd_ff[30:0], 1'b0};
            bitc_in = bitc_ff + 1'b1;
            if (bitc_ff == BCW'(ncc_pkg::DIV_STEPS - 1)) begin
               state_in = S_FIX;
            end
         end
         // sign and saturate to Q8.24
         S_FIX: begin
            if (zero_ff) begin
               norm_in = '0;
            end else if (!neg_ff) begin
               norm_in = (sat_ff || quo_ff[31]) ? {1'b0, {(VW-1){1'b1}}} : quo_ff;
            end else if (sat_ff || (quo_ff[31] && quo_ff[30:0] != '0)) begin
               norm_in = {1'b1, {(VW-1){1'b0}}};
            end else begin
               norm_in = -quo_ff;
            end
            c_in     = '0;
            state_in = S_CRD;
         end
         // centroid and sum read issued on c_ff
         S_CRD: state_in = S_CSQ;
         S_CSQ: begin
            m_in     = dmag_w[31:0];
            state_in = S_CMUL;
         end
         S_CMUL: begin
            sq_in    = 64'(m_ff) * 64'(m_ff);
            state_in = S_CACC;
         end
         S_CACC: begin
            live_in[c_ff] = 1'b1;
            if (c_last_w) begin
               state_in = last_ff ? S_FIN : S_IDLE;
            end else begin
               c_in     = c_ff + 1'b1;
               state_in = S_CRD;
            end
         end
         // status priority, then minimum search
         S_FIN: begin
            lbl_in = '0;
            c_in   = '0;
            if (!mv_ff || !counts_ok) begin
               st_in    = ncc_pkg::ST_BAD_MODEL;
               state_in = S_EMIT;
            end else if (saw_null_ff) begin
               st_in    = ncc_pkg::ST_NULL;
               state_in = S_EMIT;
            end else if (count_ff != fc_ff) begin
               st_in    = ncc_pkg::ST_DIM;
               state_in = S_EMIT;
            end else begin
               st_in    = ncc_pkg::ST_OK;
               state_in = (cc_ff > 5'd1) ? S_MRD : S_EMIT;
            end
         end
         S_MRD: state_in = S_MCMP;
         S_MCMP: begin
            if (c_ff == '0 || sum_cur_w < best_ff) begin
               best_in = sum_cur_w;
               lbl_in  = ncc_pkg::LABEL_W'(c_ff);
            end
            if (c_last_w) begin
               state_in = S_EMIT;
            end else begin
               c_in     = c_ff + 1'b1;
               state_in = S_MRD;
            end
         end
         // hand over once the output register is free
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_label_in  = lbl_ff;
               rsp_status_in = st_ff;
               count_in      = '0;
               saw_null_in   = 1'b0;
               live_in       = '0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fc_ff        <= CNTW'(1);
         cc_ff        <= CNTW'(1);
         mv_ff        <= 1'b0;
         count_ff     <= '0;
         saw_null_ff  <= 1'b0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fc_ff        <= fc_in;
         cc_ff        <= cc_in;
         mv_ff        <= mv_in;
         count_ff     <= count_in;
         saw_null_ff  <= saw_null_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      f_ff          <= f_in;
      x_ff          <= x_in;
      last_ff       <= last_in;
      rem_ff        <= rem_in;
      dvd_ff        <= dvd_in;
      dvs_ff        <= dvs_in;
      quo_ff        <= quo_in;
      neg_ff        <= neg_in;
      sat_ff        <= sat_in;
      zero_ff       <= zero_in;
      bitc_ff       <= bitc_in;
      norm_ff       <= norm_in;
      c_ff          <= c_in;
      m_ff          <= m_in;
      sq_ff         <= sq_in;
      best_ff       <= best_in;
      lbl_ff        <= lbl_in;
      st_ff         <= st_in;
      rsp_label_ff  <= rsp_label_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

FILE: src/ncc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_checker
// Port-level checks for the nearest-centroid classifier, bound to the top.
// ----------------------------------------------------------------------------
module ncc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [ncc_pkg::OP_W-1:0]           req_op,
   input logic                               req_last,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [ncc_pkg::LABEL_W-1:0]        rsp_label,
   input logic [ncc_pkg::STATUS_W-1:0]       rsp_status
);

   // a held response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // a held response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_label) && $stable(rsp_status))
      else $error("response payload changed while stalled");

   // no label without an ok status
   a_label_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ncc_pkg::ST_OK |-> rsp_label == '0)
      else $error("label set on a failed result");

   // model loads never leave the block busy
   a_load_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_op != ncc_pkg::OP_POINT |=> !req_stall)
      else $error("busy after a load transaction");

   // the closing coordinate always occupies the block
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_op == ncc_pkg::OP_POINT && req_last |=> req_stall)
      else $error("ready straight after the closing coordinate");

endmodule

bind nearest_centroid_classifier ncc_checker u_ncc_checker (.*);

FILE: sim/tb_nearest_centroid_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_centroid_classifier
// Self-checking bench: loads limit and centroid tables, streams points under
// several register settings with random gaps and stalls, and compares every
// label and status with a cycle-free predictor of the classifier.
// ----------------------------------------------------------------------------
module tb_nearest_centroid_classifier;

   localparam int NF = ncc_pkg::DEF_MAX_FEATURES;
   localparam int NC = ncc_pkg::DEF_MAX_CENTROIDS;
   localparam int SETTLE = 300;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [ncc_pkg::OP_W-1:0]    op;
      logic [ncc_pkg::INDEX_W-1:0] fi;
      logic [ncc_pkg::INDEX_W-1:0] ci;
      logic [31:0]                 value;
      logic                        nul;
      logic                        last;
   } req_item_type;

   typedef struct {
      logic [ncc_pkg::LABEL_W-1:0]  label;
      logic [ncc_pkg::STATUS_W-1:0] status;
   } verdict_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [ncc_pkg::OP_W-1:0] req_op = ncc_pkg::OP_LIMIT_LO;
   logic [ncc_pkg::INDEX_W-1:0] req_feature_index = 0;
   logic [ncc_pkg::INDEX_W-1:0] req_centroid_index = 0;
   logic signed [ncc_pkg::VALUE_W-1:0] req_value = 0;
   logic req_element_null = 0;
   logic req_last = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [ncc_pkg::LABEL_W-1:0] rsp_label;
   logic [ncc_pkg::STATUS_W-1:0] rsp_status;
   logic csr_wr_en = 0;
   logic [ncc_pkg::CSR_IDX_W-1:0] csr_index = ncc_pkg::CSR_FEATURE_COUNT;
   logic [ncc_pkg::CSR_DATA_W-1:0] csr_wdata = 0;

   nearest_centroid_classifier DUT (.*);

   // predictor state
   logic signed [31:0] low_lim [NF];
   logic signed [31:0] high_lim [NF];
   logic signed [31:0] centroid_coord [NC*NF];
   logic [63:0] dist_sum [NC];
   int coord_seen;
   bit null_seen;
   logic [4:0] n_features, n_centroids;
   bit model_ok;

   req_item_type pending_q[$];
   verdict_type verdict_q[$];
   int issued, taken, errors;
   int gap_left, rsp_wait;
   bit req_fire, no_gaps, no_stalls;
   longint cycles;

   initial begin
      forever #10 clock = ~clock;
   end

   // predicted outcome of one accepted transaction
   function automatic void classify_item(req_item_type it);
      longint rng, q, norm, d;
      logic [63:0] m, sq;
      logic [64:0] s;
      int f;
      bit counts_ok;
      verdict_type v;
      counts_ok = n_features >= 1 && n_features <= NF && n_centroids >= 1 &&
                  n_centroids <= NC;
      if (it.op == ncc_pkg::OP_LIMIT_LO) low_lim[it.fi] = it.value;
      else if (it.op == ncc_pkg::OP_LIMIT_HI) high_lim[it.fi] = it.value;
      else if (it.op == ncc_pkg::OP_CENTROID) centroid_coord[it.ci*NF + it.fi] = it.value;
      else begin
         if (it.nul) null_seen = 1;
         else if (counts_ok && coord_seen < n_features) begin
            f = coord_seen;
            rng = longint'(high_lim[f]) - longint'(low_lim[f]);
            if (rng <= 0) norm = 0;
            else begin
               q = ((longint'($signed(it.value)) - longint'(low_lim[f])) * 64'sd16777216) / rng;
               if (q > 64'sd2147483647) q = 64'sd2147483647;
               if (q < -64'sd2147483648) q = -64'sd2147483648;
               norm = q;
            end
            for (int c = 0; c < n_centroids; c++) begin
               d = norm - longint'(centroid_coord[c*NF + f]);
               m = d < 0 ? -d : d;
               sq = m * m;
               s = {1'b0, dist_sum[c]} + {1'b0, sq};
               dist_sum[c] = s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
            end
         end
         if (coord_seen < 31) coord_seen++;
         if (it.last) begin
            v.label = 0;
            v.status = ncc_pkg::ST_OK;
            if (!model_ok || !counts_ok) v.status = ncc_pkg::ST_BAD_MODEL;
            else if (null_seen) v.status = ncc_pkg::ST_NULL;
            else if (coord_seen != n_features) v.status = ncc_pkg::ST_DIM;
            else for (int c = 1; c < n_centroids; c++)
               if (dist_sum[c] < dist_sum[v.label]) v.label = ncc_pkg::LABEL_W'(c);
            verdict_q = {verdict_q, v};
            for (int c = 0; c < NC; c++) dist_sum[c] = 0;
            coord_seen = 0;
            null_seen = 0;
         end
      end
   endfunction

   // driver: presents queued transactions with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 0;
         gap_left <= 0;
      end else if (!req_valid || req_fire) begin
         if (gap_left != 0 || pending_q.size() == 0) begin
            req_valid <= 0;
            if (gap_left != 0) gap_left <= gap_left - 1;
         end else begin
            req_op <= pending_q[0].op;
            req_feature_index <= pending_q[0].fi;
            req_centroid_index <= pending_q[0].ci;
            req_value <= pending_q[0].value;
            req_element_null <= pending_q[0].nul;
            req_last <= pending_q[0].last;
            void'(pending_q.pop_front());
            req_valid <= 1;
            gap_left <= no_gaps ? 0 : $urandom_range(0, 9);
         end
      end
      rsp_stall <= !reset && rsp_wait != 0;
   end

   // monitor: predicts on accepted requests, checks accepted responses
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && !req_stall;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
      if (reset) rsp_wait <= 0;
      else if (rsp_valid && !rsp_stall) rsp_wait <= no_stalls ? 0 : $urandom_range(0, 9);
      else if (rsp_wait != 0) rsp_wait <= rsp_wait - 1;
      if (!reset && req_valid && !req_stall) begin
         classify_item('{req_op, req_feature_index, req_centroid_index, req_value,
                         req_element_null, req_last});
         taken <= taken + 1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            $display("%0t unexpected result: expected none actual label %0d status %0d",
                     $time, rsp_label, rsp_status);
            errors++;
         end else begin
            if (rsp_label !== verdict_q[0].label) begin
               $display("%0t label mismatch: expected %0d actual %0d", $time,
                        verdict_q[0].label, rsp_label);
               errors++;
            end
            if (rsp_status !== verdict_q[0].status) begin
               $display("%0t status mismatch: expected %0d actual %0d", $time,
                        verdict_q[0].status, rsp_status);
               errors++;
            end
            void'(verdict_q.pop_front());
         end
      end
   end

   task automatic queue_req(logic [ncc_pkg::OP_W-1:0] op, int fi, int ci, logic [31:0] value,
                            bit nul, bit last);
      req_item_type it;
      it.op = op;
      it.fi = ncc_pkg::INDEX_W'(fi);
      it.ci = ncc_pkg::INDEX_W'(ci);
      it.value = value;
      it.nul = nul;
      it.last = last;
      pending_q = {pending_q, it};
      issued++;
   endtask

   // wait for every transaction and result, then let the sequencer settle
   task automatic wait_idle();
      wait (pending_q.size() == 0 && issued == taken && verdict_q.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [ncc_pkg::CSR_IDX_W-1:0] idx,
                            logic [ncc_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 0;
      if (idx == ncc_pkg::CSR_FEATURE_COUNT) n_features = data;
      else if (idx == ncc_pkg::CSR_CENTROID_COUNT) n_centroids = data;
      else model_ok = data[0];
   endtask

   task automatic set_model(int fc, int cc, bit mv);
      wait_idle();
      write_reg(ncc_pkg::CSR_FEATURE_COUNT, ncc_pkg::CSR_DATA_W'(fc));
      write_reg(ncc_pkg::CSR_CENTROID_COUNT, ncc_pkg::CSR_DATA_W'(cc));
      write_reg(ncc_pkg::CSR_MODEL_VALID, ncc_pkg::CSR_DATA_W'(mv));
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 255) - 128;
         3, 4: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         default: return $urandom;
      endcase
   endfunction

   // new limits for one feature: ordinary, equal, reversed, narrow, full span or random
   task automatic load_limits(int f);
      logic [31:0] lo, hi;
      lo = $urandom_range(0, 32'h0004_0000) - 32'h0004_0000;
      hi = lo + $urandom_range(1, 32'h0008_0000);
      case ($urandom_range(0, 9))
         0: hi = lo;
         1: hi = lo - $urandom_range(1, 1000);
         2: hi = lo + 1;
         3: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
         4: begin lo = $urandom; hi = $urandom; end
         default: ;
      endcase
      queue_req(ncc_pkg::OP_LIMIT_LO, f, $urandom_range(0, 15), lo, $urandom_range(0, 1),
                $urandom_range(0, 1));
      queue_req(ncc_pkg::OP_LIMIT_HI, f, $urandom_range(0, 15), hi, $urandom_range(0, 1),
                $urandom_range(0, 1));
   endtask

   // one point of n coordinates, null at position null_at (none if negative)
   task automatic send_point(int n, int null_at);
      for (int i = 0; i < n; i++)
         queue_req(ncc_pkg::OP_POINT, $urandom_range(0, 15), $urandom_range(0, 15),
                   pick_value(), i == null_at, i == n - 1);
   endtask

   task automatic random_points(int budget, int mode_ok);
      int n, kind;
      while (budget > 0) begin
         kind = $urandom_range(0, 19);
         if (kind == 0) begin
            load_limits($urandom_range(0, 15));
            budget -= 2;
         end else if (kind == 1) begin
            queue_req(ncc_pkg::OP_CENTROID, $urandom_range(0, 15), $urandom_range(0, 15),
                      $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
            budget--;
         end else begin
            n = (mode_ok && kind > 4) ? n_features : $urandom_range(1, 20);
            if (n == 0) n = 1;
            send_point(n, (kind == 2) ? $urandom_range(0, n - 1) : -1);
            budget -= n;
         end
      end
   endtask

   initial begin
      int fc, cc;
      for (int c = 0; c < NC; c++) dist_sum[c] = 0;
      coord_seen = 0; null_seen = 0;
      n_features = 1; n_centroids = 1; model_ok = 0;
      issued = 0; taken = 0; errors = 0; cycles = 0;
      no_gaps = 0; no_stalls = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // fill every table entry before any point reads one
      for (int f = 0; f < NF; f++) load_limits(f);
      for (int c = 0; c < NC; c++)
         for (int f = 0; f < NF; f++)
            queue_req(ncc_pkg::OP_CENTROID, f, c, $urandom, 0, 0);

      // directed: extremes, statuses, single centroid, count saturation
      set_model(2, 2, 1);
      queue_req(ncc_pkg::OP_LIMIT_LO, 0, 0, 32'h8000_0000, 0, 0);
      queue_req(ncc_pkg::OP_LIMIT_HI, 0, 0, 32'h7FFF_FFFF, 0, 0);
      queue_req(ncc_pkg::OP_LIMIT_LO, 1, 0, 32'h0001_0000, 0, 0);
      queue_req(ncc_pkg::OP_LIMIT_HI, 1, 0, 32'h0001_0000, 0, 0);
      queue_req(ncc_pkg::OP_CENTROID, 0, 1, 32'h7FFF_FFFF, 0, 0);
      send_point(2, -1);
      queue_req(ncc_pkg::OP_POINT, 0, 0, 32'h7FFF_FFFF, 0, 0);
      queue_req(ncc_pkg::OP_POINT, 0, 0, 32'h8000_0000, 0, 1);
      send_point(2, 0);
      send_point(1, -1);
      send_point(3, -1);
      queue_req(ncc_pkg::OP_LIMIT_HI, 1, 0, 32'h0001_0001, 0, 0);
      send_point(2, -1);
      set_model(1, 1, 1);
      send_point(1, -1);
      send_point(34, -1);
      set_model(2, 2, 0);
      send_point(2, 1);

      // random phases across settings, extremes first
      for (int ph = 0; issued < 1490; ph++) begin
         case (ph)
            0: begin fc = 16; cc = 16; end
            1: begin fc = 1;  cc = 16; end
            2: begin fc = 16; cc = 1;  end
            3: begin fc = 0;  cc = 4;  end
            4: begin fc = 3;  cc = 0;  end
            5: begin fc = 17 + $urandom_range(0, 14); cc = 2; end
            6: begin fc = 2;  cc = 17 + $urandom_range(0, 14); end
            default: begin fc = $urandom_range(1, 8); cc = $urandom_range(1, 16); end
         endcase
         no_gaps = (ph % 4 == 1);
         no_stalls = (ph % 5 == 2);
         set_model(fc, cc, (ph == 7) ? 0 : 1);
         random_points(60, 1);
         if (ph == 8) wait_idle();
         random_points(60, 1);
      end

      wait_idle();
      if (errors == 0 && verdict_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
